FILE: hdl/fpsa_pkg.sv
// shared types and constants for the fit-policy segment allocator
package fpsa_pkg;

  // pool geometry, fixed by the port widths
  localparam int ADDR_BITS    = 16;
  localparam int MAX_SEGMENTS = 32;

  // operation kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_NOT_LIVE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // fit policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;

  // configuration register indexes
  localparam logic CFG_FIT  = 1'b0;
  localparam logic CFG_POOL = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD,
    CMD_SCAN_LIVE,
    CMD_SCAN_FREE,
    CMD_APPLY_ALLOC,
    CMD_APPLY_FREE,
    CMD_SHIFT,
    CMD_FINISH
  } cmd_e;

  // status from datapath to controller
  typedef struct packed {
    logic live_done;
    logic free_done;
    logic shift_done;
    logic need_shift;
    logic apply_ok;
  } dp_status_t;

endpackage

FILE: hdl/fpsa_ctrl.sv
// controller state machine for the segment allocator
module fpsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_valid_i,
  input  logic                is_free_i,
  input  fpsa_pkg::dp_status_t st_i,
  output fpsa_pkg::cmd_e      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LIVE  = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  // accept only with the output slot free
  assign in_stall_o = (state_q != S_IDLE) || out_valid_i;

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = fpsa_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o   = fpsa_pkg::CMD_LOAD;
          state_d = S_LIVE;
        end
      end
      S_LIVE: begin
        cmd_o = fpsa_pkg::CMD_SCAN_LIVE;
        if (st_i.live_done) state_d = S_FREE;
      end
      S_FREE: begin
        cmd_o = fpsa_pkg::CMD_SCAN_FREE;
        if (st_i.free_done) state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o = is_free_i ? fpsa_pkg::CMD_APPLY_FREE : fpsa_pkg::CMD_APPLY_ALLOC;
        state_d = (st_i.apply_ok && st_i.need_shift) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd_o = fpsa_pkg::CMD_SHIFT;
        if (st_i.shift_done) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o   = fpsa_pkg::CMD_FINISH;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/fpsa_dp.sv
// datapath for the segment allocator: tables, scans and result word
module fpsa_dp #(
  parameter int MAX_LIVE     = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpsa_pkg::cmd_e       cmd_i,
  output fpsa_pkg::dp_status_t st_o,
  output logic                 is_free_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [16:0]          cfg_data_i,
  input  logic                 kind_i,
  input  logic [16:0]          req_size_i,
  input  logic [15:0]          block_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [15:0]          granted_addr_o,
  output logic [16:0]          free_bytes_o,
  output logic [5:0]           free_segments_o
);

  localparam int SW = $clog2(fpsa_pkg::MAX_SEGMENTS);
  localparam int CW = $clog2(fpsa_pkg::MAX_SEGMENTS + 1);
  localparam int LW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
  localparam int LC = $clog2(MAX_LIVE + 1);
  localparam logic [16:0] CAP_LIM = 17'(64'd1 << fpsa_pkg::ADDR_BITS);

  // free table as per-entry registers, shifted in place
  logic [15:0]  fbase_q [fpsa_pkg::MAX_SEGMENTS];
  logic [16:0]  flen_q  [fpsa_pkg::MAX_SEGMENTS];
  logic [CW-1:0] used_q;
  logic [15:0]  lbase_q [MAX_LIVE];
  logic [16:0]  llen_q  [MAX_LIVE];
  logic [MAX_LIVE-1:0] lvalid_q;

  logic [1:0]  fit_q;
  logic [16:0] fbytes_q;

  // captured item
  logic        kind_q;
  logic [16:0] size_q;
  logic [15:0] addr_q;

  // scan state
  logic [LC-1:0] li_q;
  logic [CW-1:0] fi_q;
  logic          slot_ok_q;
  logic [LW-1:0] slot_q;
  logic          pick_ok_q;
  logic [SW-1:0] pick_q;
  logic [16:0]   pick_len_q;
  logic [CW-1:0] pos_q;
  logic          pos_stop_q;
  logic [16:0]   blen_q;

  // shift state
  logic          shift_up_q;
  logic [CW-1:0] sh_q;
  logic [CW-1:0] sh_end_q;
  logic [15:0]   ins_base_q;
  logic [16:0]   ins_len_q;

  logic [2:0]  status_q;
  logic [15:0] grant_q;
  logic        ovalid_q;

  logic [16:0] cfg_pool;
  assign cfg_pool = (cfg_data_i > CAP_LIM) ? CAP_LIM : cfg_data_i;

  assign is_free_o = kind_q;

  // scan helpers
  logic [LW-1:0] li;
  logic [SW-1:0] fi;
  logic          fit_hit, better;
  assign li = li_q[LW-1:0];
  assign fi = fi_q[SW-1:0];
  assign fit_hit = flen_q[fi] >= size_q;
  always_comb begin
    if (!pick_ok_q)                 better = 1'b1;
    else if (fit_q == fpsa_pkg::FIT_FIRST) better = 1'b0;
    else if (fit_q == fpsa_pkg::FIT_BEST)  better = flen_q[fi] < pick_len_q;
    else                             better = flen_q[fi] > pick_len_q;
  end

  // neighbour checks for free
  logic [SW-1:0] pm1, pp;
  logic          jp, jn;
  logic [16:0]   prev_end, blk_end;
  assign pm1 = SW'(pos_q - CW'(1));
  assign pp  = pos_q[SW-1:0];
  assign prev_end = 17'(fbase_q[pm1]) + flen_q[pm1];
  assign blk_end  = 17'(addr_q) + blen_q;
  assign jp = (pos_q != '0) && (prev_end == 17'(addr_q));
  assign jn = (pos_q < used_q) && (blk_end == 17'(fbase_q[pp]));

  logic alloc_full;
  assign alloc_full = (flen_q[pick_q] == size_q);

  always_comb begin
    st_o.live_done  = (li_q == LC'(MAX_LIVE)) || slot_ok_q;
    st_o.free_done  = (fi_q >= used_q);
    st_o.shift_done = (sh_q == sh_end_q);
    if (kind_q == fpsa_pkg::KIND_ALLOC) begin
      st_o.apply_ok   = (size_q != '0) && slot_ok_q && pick_ok_q;
      st_o.need_shift = alloc_full;
    end else begin
      st_o.apply_ok   = slot_ok_q &&
                        ((jp || jn) || (used_q < CW'(fpsa_pkg::MAX_SEGMENTS)));
      st_o.need_shift = (jp && jn) || (!jp && !jn);
    end
  end

  // sequencing of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fpsa_pkg::MAX_SEGMENTS; i++) begin
        fbase_q[i] <= '0;
        flen_q[i]  <= '0;
      end
      for (int i = 0; i < MAX_LIVE; i++) begin
        lbase_q[i] <= '0;
        llen_q[i]  <= '0;
      end
      flen_q[0]  <= CAP_LIM;
      used_q     <= CW'(1);
      fbytes_q   <= CAP_LIM;
      lvalid_q   <= '0;
      fit_q      <= fpsa_pkg::FIT_FIRST;
      ovalid_q   <= 1'b0;
      li_q       <= '0;
      fi_q       <= '0;
      slot_ok_q  <= 1'b0;
      slot_q     <= '0;
      pick_ok_q  <= 1'b0;
      pick_q     <= '0;
      pick_len_q <= '0;
      pos_q      <= '0;
      pos_stop_q <= 1'b0;
      blen_q     <= '0;
      shift_up_q <= 1'b0;
      sh_q       <= '0;
      sh_end_q   <= '0;
      ins_base_q <= '0;
      ins_len_q  <= '0;
      status_q   <= fpsa_pkg::ST_OK;
      grant_q    <= '0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == fpsa_pkg::CFG_FIT) begin
          fit_q <= cfg_data_i[1:0];
        end else begin
          for (int i = 0; i < fpsa_pkg::MAX_SEGMENTS; i++) begin
            fbase_q[i] <= '0;
            flen_q[i]  <= '0;
          end
          flen_q[0] <= cfg_pool;
          used_q    <= (cfg_pool != '0) ? CW'(1) : CW'(0);
          fbytes_q  <= cfg_pool;
          lvalid_q  <= '0;
        end
      end
      unique case (cmd_i)
        fpsa_pkg::CMD_LOAD: begin
          li_q <= '0; fi_q <= '0; slot_ok_q <= 1'b0; pick_ok_q <= 1'b0;
          pos_q <= '0; pos_stop_q <= 1'b0;
        end
        fpsa_pkg::CMD_SCAN_LIVE: begin
          if (li_q != LC'(MAX_LIVE) && !slot_ok_q) begin
            li_q <= li_q + LC'(1);
            if (kind_q == fpsa_pkg::KIND_ALLOC ? !lvalid_q[li]
                : (lvalid_q[li] && lbase_q[li] == addr_q)) begin
              slot_ok_q <= 1'b1;
              slot_q    <= li;
              blen_q    <= llen_q[li];
            end
          end
        end
        fpsa_pkg::CMD_SCAN_FREE: begin
          if (fi_q < used_q) begin
            fi_q <= fi_q + CW'(1);
            if (fit_hit && better) begin
              pick_ok_q  <= 1'b1;
              pick_q     <= fi;
              pick_len_q <= flen_q[fi];
            end
            if (!pos_stop_q && fbase_q[fi] <= addr_q) pos_q <= fi_q + CW'(1);
            else pos_stop_q <= 1'b1;
          end
        end
        fpsa_pkg::CMD_APPLY_ALLOC: begin
          if (size_q == '0)            status_q <= fpsa_pkg::ST_ZERO;
          else if (!slot_ok_q)         status_q <= fpsa_pkg::ST_FULL;
          else if (!pick_ok_q)         status_q <= fpsa_pkg::ST_NO_FIT;
          else                         status_q <= fpsa_pkg::ST_OK;
          grant_q <= st_o.apply_ok ? fbase_q[pick_q] : '0;
          if (st_o.apply_ok) begin
            lbase_q[slot_q]  <= fbase_q[pick_q];
            llen_q[slot_q]   <= size_q;
            lvalid_q[slot_q] <= 1'b1;
            fbytes_q         <= fbytes_q - size_q;
            if (alloc_full) begin
              // remove entry pick, shift down the tail
              shift_up_q <= 1'b0;
              sh_q       <= CW'(pick_q);
              sh_end_q   <= used_q - CW'(1);
            end else begin
              fbase_q[pick_q] <= fbase_q[pick_q] + size_q[15:0];
              flen_q[pick_q]  <= flen_q[pick_q] - size_q;
            end
          end
        end
        fpsa_pkg::CMD_APPLY_FREE: begin
          grant_q <= '0;
          if (!slot_ok_q)          status_q <= fpsa_pkg::ST_NOT_LIVE;
          else if (!st_o.apply_ok) status_q <= fpsa_pkg::ST_FULL;
          else                     status_q <= fpsa_pkg::ST_OK;
          if (st_o.apply_ok) begin
            lvalid_q[slot_q] <= 1'b0;
            fbytes_q <= fbytes_q + blen_q;
            if (jp && jn) begin
              flen_q[pm1] <= flen_q[pm1] + blen_q + flen_q[pp];
              shift_up_q <= 1'b0;
              sh_q       <= pos_q;
              sh_end_q   <= used_q - CW'(1);
            end else if (jp) begin
              flen_q[pm1] <= flen_q[pm1] + blen_q;
            end else if (jn) begin
              fbase_q[pp] <= addr_q;
              flen_q[pp]  <= flen_q[pp] + blen_q;
            end else begin
              // open a hole at pos, shifting the tail up
              shift_up_q <= 1'b1;
              sh_q       <= used_q;
              sh_end_q   <= pos_q;
              ins_base_q <= addr_q;
              ins_len_q  <= blen_q;
            end
          end
        end
        fpsa_pkg::CMD_SHIFT: begin
          if (sh_q != sh_end_q) begin
            if (shift_up_q) begin
              fbase_q[SW'(sh_q)] <= fbase_q[SW'(sh_q - CW'(1))];
              flen_q[SW'(sh_q)]  <= flen_q[SW'(sh_q - CW'(1))];
              sh_q <= sh_q - CW'(1);
            end else begin
              fbase_q[SW'(sh_q)] <= fbase_q[SW'(sh_q + CW'(1))];
              flen_q[SW'(sh_q)]  <= flen_q[SW'(sh_q + CW'(1))];
              sh_q <= sh_q + CW'(1);
            end
          end else if (shift_up_q) begin
            fbase_q[SW'(sh_q)] <= ins_base_q;
            flen_q[SW'(sh_q)]  <= ins_len_q;
            used_q <= used_q + CW'(1);
          end else begin
            fbase_q[SW'(sh_q)] <= '0;
            flen_q[SW'(sh_q)]  <= '0;
            used_q <= used_q - CW'(1);
          end
        end
        fpsa_pkg::CMD_FINISH: begin
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i == fpsa_pkg::CMD_LOAD) begin
      kind_q <= kind_i;
      size_q <= req_size_i;
      addr_q <= block_addr_i;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign status_o        = status_q;
  assign granted_addr_o  = grant_q;
  assign free_bytes_o    = fbytes_q;
  assign free_segments_o = 6'(used_q);

endmodule

FILE: hdl/fit_policy_segment_allocator_core.sv
// top level of the fit-policy segment allocator
// each word is loaded, then runs a live-table scan, a free-table scan, an apply step, a table
//   shift when the free table must change length, and a finish step
// throughput: one word at a time; the next word is taken the cycle after the result is taken
// reset: fit policy first fit, one free segment covering the whole pool, no live blocks
module fit_policy_segment_allocator_core #(
  parameter int MAX_LIVE     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [16:0] req_size_i,
  input  logic [15:0] block_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] granted_addr_o,
  output logic [16:0] free_bytes_o,
  output logic [5:0]  free_segments_o
);

  fpsa_pkg::cmd_e       cmd;
  fpsa_pkg::dp_status_t st;
  logic                 is_free;

  // controller
  fpsa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .out_valid_i(out_valid_o), .is_free_i(is_free),
    .st_i(st), .cmd_o(cmd)
  );

  // datapath
  fpsa_dp #(
    .MAX_LIVE(MAX_LIVE)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .st_o(st), .is_free_o(is_free),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .kind_i, .req_size_i, .block_addr_i,
    .out_valid_o, .out_stall_i,
    .status_o, .granted_addr_o, .free_bytes_o, .free_segments_o
  );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the fit-policy segment allocator core
module tb_top;

  localparam int NSEG  = fpsa_pkg::MAX_SEGMENTS;
  localparam int NLIVE = 32;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_UNDEF = 2'd3;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic        kind;
    logic [16:0] size;
    logic [15:0] addr;
  } word_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] granted;
    logic [16:0] free_bytes;
    logic [5:0]  free_segs;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = fpsa_pkg::CFG_FIT;
  logic [16:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = fpsa_pkg::KIND_ALLOC;
  logic [16:0] req_size_i = '0;
  logic [15:0] block_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] granted_addr_o;
  logic [16:0] free_bytes_o;
  logic [5:0]  free_segments_o;

  fit_policy_segment_allocator_core dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator mirror: sorted free list and live block table
  int  seg_base [NSEG];
  int  seg_len  [NSEG];
  int  seg_count;
  int  blk_base [NLIVE];
  int  blk_len  [NLIVE];
  bit  blk_live [NLIVE];
  logic [1:0] mirror_fit;
  int  mirror_pool;

  word_t    word_q [$];
  outcome_t outcome_q [$];
  int errors = 0;
  bit hold_req = 1'b0;

  function automatic void tables_reset();
    for (int i = 0; i < NSEG; i++) begin
      seg_base[i] = 0;
      seg_len[i] = 0;
    end
    for (int i = 0; i < NLIVE; i++) blk_live[i] = 1'b0;
    seg_len[0] = mirror_pool;
    seg_count = (mirror_pool > 0) ? 1 : 0;
  endfunction

  function automatic void seg_drop(int p);
    for (int i = p; i < seg_count - 1; i++) begin
      seg_base[i] = seg_base[i+1];
      seg_len[i] = seg_len[i+1];
    end
    seg_count--;
    seg_base[seg_count] = 0;
    seg_len[seg_count] = 0;
  endfunction

  function automatic logic [2:0] grant_block(int size, output int granted);
    int slot;
    int pick;
    slot = -1;
    pick = -1;
    granted = 0;
    if (size == 0) return fpsa_pkg::ST_ZERO;
    for (int i = 0; i < NLIVE; i++)
      if (!blk_live[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return fpsa_pkg::ST_FULL;
    for (int i = 0; i < seg_count; i++) begin
      if (seg_len[i] < size) continue;
      if (mirror_fit == fpsa_pkg::FIT_FIRST) begin
        pick = i;
        break;
      end
      if (pick < 0) pick = i;
      else if (mirror_fit == fpsa_pkg::FIT_BEST) begin
        if (seg_len[i] < seg_len[pick]) pick = i;
      end else if (seg_len[i] > seg_len[pick]) pick = i;
    end
    if (pick < 0) return fpsa_pkg::ST_NO_FIT;
    granted = seg_base[pick];
    blk_base[slot] = seg_base[pick];
    blk_len[slot] = size;
    blk_live[slot] = 1'b1;
    if (seg_len[pick] == size) seg_drop(pick);
    else begin
      seg_base[pick] += size;
      seg_len[pick] -= size;
    end
    return fpsa_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] release_block(int addr);
    int  slot;
    int  p;
    int  len;
    bit  lo;
    bit  hi;
    slot = -1;
    for (int i = 0; i < NLIVE; i++)
      if (blk_live[i] && blk_base[i] == addr) begin
        slot = i;
        break;
      end
    if (slot < 0) return fpsa_pkg::ST_NOT_LIVE;
    len = blk_len[slot];
    for (p = 0; p < seg_count; p++)
      if (seg_base[p] > addr) break;
    lo = p > 0 && seg_base[p-1] + seg_len[p-1] == addr;
    hi = p < seg_count && addr + len == seg_base[p];
    if (lo && hi) begin
      seg_len[p-1] += len + seg_len[p];
      seg_drop(p);
    end else if (lo) seg_len[p-1] += len;
    else if (hi) begin
      seg_base[p] = addr;
      seg_len[p] += len;
    end else begin
      if (seg_count >= NSEG) return fpsa_pkg::ST_FULL;
      for (int i = seg_count; i > p; i--) begin
        seg_base[i] = seg_base[i-1];
        seg_len[i] = seg_len[i-1];
      end
      seg_base[p] = addr;
      seg_len[p] = len;
      seg_count++;
    end
    blk_live[slot] = 1'b0;
    return fpsa_pkg::ST_OK;
  endfunction

  // queue a word and its predicted outcome, in acceptance order
  task automatic push_word(logic kind, logic [16:0] size, logic [15:0] addr);
    word_t    w;
    outcome_t o;
    int       g;
    int       sum;
    w.kind = kind;
    w.size = size;
    w.addr = addr;
    g = 0;
    if (kind == fpsa_pkg::KIND_ALLOC) o.status = grant_block(int'(size), g);
    else o.status = release_block(int'(addr));
    sum = 0;
    for (int i = 0; i < seg_count; i++) sum += seg_len[i];
    o.granted = (o.status == fpsa_pkg::ST_OK) ? g[15:0] : 16'd0;
    o.free_bytes = sum[16:0];
    o.free_segs = seg_count[5:0];
    word_q.push_back(w);
    outcome_q.push_back(o);
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [16:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fpsa_pkg::CFG_FIT) mirror_fit = data[1:0];
    else begin
      mirror_pool = (int'(data) > 65536) ? 65536 : int'(data);
      tables_reset();
    end
  endtask

  // one random word: mostly well-formed alloc/free traffic, some noise
  task automatic push_random();
    int r;
    int cap;
    int live_idx [$];
    r = $urandom_range(0, 99);
    cap = (mirror_pool >> 4) < 1 ? 1 : (mirror_pool >> 4);
    for (int i = 0; i < NLIVE; i++) if (blk_live[i]) live_idx.push_back(i);
    if (r < 50 || (r < 88 && live_idx.size() == 0))
      push_word(fpsa_pkg::KIND_ALLOC, 17'($urandom_range(1, cap)), 16'($urandom));
    else if (r < 54) push_word(fpsa_pkg::KIND_ALLOC, 17'($urandom), 16'($urandom));
    else if (r < 56) push_word(fpsa_pkg::KIND_ALLOC, 17'd0, 16'($urandom));
    else if (r < 88)
      push_word(fpsa_pkg::KIND_FREE, 17'($urandom),
                16'(blk_base[live_idx[$urandom_range(0, live_idx.size() - 1)]]));
    else if (r < 92 && live_idx.size() != 0)
      push_word(fpsa_pkg::KIND_FREE, 17'($urandom), 16'(blk_base[live_idx[0]] + 1));
    else push_word(fpsa_pkg::KIND_FREE, 17'($urandom), 16'($urandom));
  endtask

  // stimulus sequence
  initial begin
    static logic [1:0]  fits  [9] = '{fpsa_pkg::FIT_FIRST, fpsa_pkg::FIT_BEST, FIT_WORST,
                                      FIT_UNDEF, fpsa_pkg::FIT_FIRST, fpsa_pkg::FIT_BEST,
                                      fpsa_pkg::FIT_FIRST, FIT_WORST, fpsa_pkg::FIT_BEST};
    static logic [16:0] pools [9] = '{17'd65536, 17'd4096, 17'd4096, 17'd256, 17'd1,
                                      17'd100000, 17'd0, 17'd131071, 17'd64};
    static int counts [9] = '{200, 250, 250, 200, 60, 200, 40, 200, 300};
    mirror_fit = fpsa_pkg::FIT_FIRST;
    mirror_pool = 65536;
    tables_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: boundaries, every status except full, no merge, merge with next and with both
    push_word(fpsa_pkg::KIND_ALLOC, 17'd0, 16'd0);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd65537, 16'd0);
    push_word(fpsa_pkg::KIND_ALLOC, 17'h1ffff, 16'hffff);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd65536, 16'd0);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd1, 16'd0);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd0);
    push_word(fpsa_pkg::KIND_FREE, 17'h1ffff, 16'hffff);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd0);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd100, 16'd0);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd200, 16'd0);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd300, 16'd0);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd50, 16'd0);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd100);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd0);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd600);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd300);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd5);
    push_word(fpsa_pkg::KIND_ALLOC, 17'd65535, 16'd0);
    push_word(fpsa_pkg::KIND_FREE, 17'd0, 16'd0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      cfg_write(fpsa_pkg::CFG_FIT, {15'd0, fits[ph]});
      cfg_write(fpsa_pkg::CFG_POOL, pools[ph]);
      if (ph == 1) begin
        @(posedge clk_i);
        hold_req = 1'b1;
      end
      for (int n = 0; n < counts[ph]; n++) push_random();
      wait_idle();
    end

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  // sender: bursts with random gaps, payload held while stalled
  bit taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) taken <= in_valid_i && !in_stall_o;

  always @(negedge clk_i) begin
    if (!in_valid_i || taken) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_q.size() != 0) begin
        word_t w;
        w = word_q.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= w.kind;
        req_size_i <= w.size;
        block_addr_i <= w.addr;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else burst_left <= burst_left - 1;
      end else in_valid_i <= 1'b0;
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  int hold_cnt = 0;
  int mode_left = 0;
  bit noisy = 1'b0;
  bit hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(50, 500);
        noisy <= $urandom_range(0, 1);
      end else mode_left <= mode_left - 1;
      out_stall_i <= noisy && ($urandom_range(0, 3) == 0);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected word: status %0d addr %0d", $time, status_o,
                 granted_addr_o);
        errors++;
      end else begin
        outcome_t e;
        e = outcome_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (granted_addr_o !== e.granted) begin
          $display("%0t: granted_addr expected %0d actual %0d", $time, e.granted,
                   granted_addr_o);
          errors++;
        end
        if (free_bytes_o !== e.free_bytes) begin
          $display("%0t: free_bytes expected %0d actual %0d", $time, e.free_bytes,
                   free_bytes_o);
          errors++;
        end
        if (free_segments_o !== e.free_segs) begin
          $display("%0t: free_segments expected %0d actual %0d", $time, e.free_segs,
                   free_segments_o);
          errors++;
        end
      end
    end
  end

endmodule
